FILE: hdl/erws_pkg.sv
// Shared types and constants for the event record window scanner.
// Used by erws_parser and event_record_window_scanner_core; depends on nothing.
`default_nettype none

package erws_pkg;

   typedef enum logic [2:0] {
      PH_DATE,
      PH_DATE2,
      PH_PLANET1,
      PH_PLANET2,
      PH_DEGREE,
      PH_DONE
   } phase_type;

   typedef logic [1:0] csr_index_type;

   localparam csr_index_type REG_RECORD_FLAGS = 2'd0;
   localparam csr_index_type REG_RECORD_COUNT = 2'd1;
   localparam csr_index_type REG_DAY_START    = 2'd2;
   localparam csr_index_type REG_DAY_END      = 2'd3;

   localparam int FLAG_DATE2        = 0;
   localparam int FLAG_PLANET1      = 1;
   localparam int FLAG_PLANET2      = 2;
   localparam int FLAG_DEGREE       = 3;
   localparam int FLAG_BYTE_DELTA   = 4;
   localparam int FLAG_WORD_DELTA   = 5;
   localparam int FLAG_SHORT_DEGREE = 6;
   localparam int FLAG_CHAINED_END  = 7;

   typedef struct packed {
      logic [7:0]  record_flags;
      logic [15:0] record_count;
      logic [31:0] day_start;
      logic [31:0] day_end;
   } cfg_type;

   typedef struct packed {
      logic        valid;
      logic        found;
      logic [31:0] event_start;
      logic [31:0] event_end;
   } emit_type;

endpackage

`default_nettype wire

FILE: hdl/erws_parser.sv
// Record parser: scan state registers and the per-beat next-state logic.
// Depends on erws_pkg; instantiated by event_record_window_scanner_core.
`default_nettype none

module erws_parser #(
   parameter int DAY_MINUTES = 1440
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step_en,
   input  wire logic [7:0]       data_byte,
   input  wire logic             first_byte,
   input  wire erws_pkg::cfg_type cfg,
   output erws_pkg::emit_type    emit
);

   erws_pkg::phase_type phase_ff, phase_in;
   logic [1:0]          bif_ff, bif_in;
   logic [31:0]         acc_ff, acc_in;
   logic [31:0]         date_ff, date_in;
   logic [31:0]         cend_ff, cend_in;
   logic [31:0]         pstart_ff, pstart_in;
   logic [31:0]         pend_ff, pend_in;
   logic [15:0]         idx_ff, idx_in;
   logic                fin_ff, fin_in;

   erws_pkg::phase_type phase_e, phase0, phase_nx;
   logic [1:0]          bif_e, bif_nx;
   logic [31:0]         acc_e, acc_sh;
   logic [31:0]         date_e, date_nx;
   logic [31:0]         cend_e, cend_nx;
   logic [31:0]         pstart_e, pend_e, pend_chain;
   logic [15:0]         idx_e, idx_nx;
   logic                fin_e;
   logic                date_byte, date_word;
   logic [2:0]          width;
   logic [31:0]         delta, day_step, step_secs;
   logic [31:0]         cur_start, cur_end;
   logic                prev_hit, cur_hit;
   logic [7:0]          f;

   function automatic erws_pkg::phase_type next_phase(input logic [2:0] from,
                                                      input logic [7:0] flags);
      erws_pkg::phase_type ph;
      begin
         if (from == 3'(erws_pkg::PH_DATE))
            ph = erws_pkg::PH_DATE;
         else if (from <= 3'(erws_pkg::PH_DATE2) && flags[erws_pkg::FLAG_DATE2])
            ph = erws_pkg::PH_DATE2;
         else if (from <= 3'(erws_pkg::PH_PLANET1) && flags[erws_pkg::FLAG_PLANET1])
            ph = erws_pkg::PH_PLANET1;
         else if (from <= 3'(erws_pkg::PH_PLANET2) && flags[erws_pkg::FLAG_PLANET2])
            ph = erws_pkg::PH_PLANET2;
         else if (from <= 3'(erws_pkg::PH_DEGREE) && flags[erws_pkg::FLAG_DEGREE])
            ph = erws_pkg::PH_DEGREE;
         else
            ph = erws_pkg::PH_DONE;
         return ph;
      end
   endfunction

   function automatic logic in_window(input logic [31:0] s, input logic [31:0] lo,
                                      input logic [31:0] hi);
      return (s != 32'd0) && ($signed(s) >= $signed(lo)) && ($signed(s) < $signed(hi));
   endfunction

   always_comb begin
      f = cfg.record_flags;

      // restart clears the scan before the beat is taken
      phase_e  = first_byte ? erws_pkg::PH_DATE : phase_ff;
      bif_e    = first_byte ? 2'd0  : bif_ff;
      acc_e    = first_byte ? 32'd0 : acc_ff;
      date_e   = first_byte ? 32'd0 : date_ff;
      cend_e   = first_byte ? 32'd0 : cend_ff;
      pstart_e = first_byte ? 32'd0 : pstart_ff;
      pend_e   = first_byte ? 32'd0 : pend_ff;
      idx_e    = first_byte ? 16'd0 : idx_ff;
      fin_e    = first_byte ? 1'b0  : fin_ff;

      phase0    = (phase_e == erws_pkg::PH_DONE) ? erws_pkg::PH_DATE : phase_e;
      acc_sh    = {acc_e[23:0], data_byte};
      bif_nx    = bif_e + 2'd1;
      date_byte = (idx_e != 16'd0) && f[erws_pkg::FLAG_BYTE_DELTA];
      date_word = (idx_e != 16'd0) && !f[erws_pkg::FLAG_BYTE_DELTA]
                  && f[erws_pkg::FLAG_WORD_DELTA];

      case (phase0)
         erws_pkg::PH_DATE:   width = date_byte ? 3'd1 : (date_word ? 3'd2 : 3'd4);
         erws_pkg::PH_DATE2:  width = 3'd4;
         erws_pkg::PH_DEGREE: width = f[erws_pkg::FLAG_SHORT_DEGREE] ? 3'd1 : 3'd2;
         default:             width = 3'd1;
      endcase

      delta     = date_byte ? {{24{acc_sh[7]}}, acc_sh[7:0]}
                            : {{16{acc_sh[15]}}, acc_sh[15:0]};
      day_step  = delta + 32'(DAY_MINUTES);
      step_secs = (day_step << 6) - (day_step << 2);

      date_nx = date_e;
      cend_nx = cend_e;
      if (phase0 == erws_pkg::PH_DATE)
         date_nx = (date_byte || date_word) ? date_e + step_secs : acc_sh;
      else if (phase0 == erws_pkg::PH_DATE2)
         cend_nx = acc_sh;

      phase_nx   = next_phase(3'(phase0) + 3'd1, f);
      cur_start  = date_nx;
      cur_end    = f[erws_pkg::FLAG_DATE2] ? cend_nx : date_nx;
      pend_chain = f[erws_pkg::FLAG_CHAINED_END] ? cur_start : pend_e;
      idx_nx     = idx_e + 16'd1;
      prev_hit   = in_window(pstart_e, cfg.day_start, cfg.day_end);
      cur_hit    = in_window(cur_start, cfg.day_start, cfg.day_end);

      phase_in  = phase_e;
      bif_in    = bif_e;
      acc_in    = acc_e;
      date_in   = date_e;
      cend_in   = cend_e;
      pstart_in = pstart_e;
      pend_in   = pend_e;
      idx_in    = idx_e;
      fin_in    = fin_e;
      emit      = '0;

      if (fin_e) begin
         // drop the beat until a restart
      end else if (idx_e >= cfg.record_count) begin
         emit.valid       = 1'b1;
         emit.found       = prev_hit;
         emit.event_start = prev_hit ? pstart_e : 32'd0;
         emit.event_end   = prev_hit ? pend_e : 32'd0;
         fin_in           = 1'b1;
      end else if (bif_nx != 2'd0 && {1'b0, bif_nx} < width) begin
         phase_in = phase0;
         acc_in   = acc_sh;
         bif_in   = bif_nx;
      end else begin
         acc_in  = 32'd0;
         bif_in  = 2'd0;
         date_in = date_nx;
         cend_in = cend_nx;
         if (phase_nx != erws_pkg::PH_DONE) begin
            phase_in = phase_nx;
         end else begin
            phase_in = erws_pkg::PH_DATE;
            if (prev_hit) begin
               pend_in          = pend_chain;
               emit.valid       = 1'b1;
               emit.found       = 1'b1;
               emit.event_start = pstart_e;
               emit.event_end   = pend_chain;
               fin_in           = 1'b1;
            end else begin
               pstart_in = cur_start;
               pend_in   = cur_end;
               idx_in    = idx_nx;
               if (idx_nx >= cfg.record_count || idx_nx == 16'd0) begin
                  emit.valid       = 1'b1;
                  emit.found       = cur_hit;
                  emit.event_start = cur_hit ? cur_start : 32'd0;
                  emit.event_end   = cur_hit ? cur_end : 32'd0;
                  fin_in           = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= erws_pkg::PH_DATE;
         bif_ff    <= 2'd0;
         acc_ff    <= 32'd0;
         date_ff   <= 32'd0;
         cend_ff   <= 32'd0;
         pstart_ff <= 32'd0;
         pend_ff   <= 32'd0;
         idx_ff    <= 16'd0;
         fin_ff    <= 1'b0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         bif_ff    <= bif_in;
         acc_ff    <= acc_in;
         date_ff   <= date_in;
         cend_ff   <= cend_in;
         pstart_ff <= pstart_in;
         pend_ff   <= pend_in;
         idx_ff    <= idx_in;
         fin_ff    <= fin_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/event_record_window_scanner_core.sv
// Event record window scanner top level: input beat register, config
// registers, result register. Depends on erws_pkg and erws_parser.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_data_byte, req_first_byte
//   rsp      out        rsp_valid / rsp_stall  rsp_found, rsp_event_start, rsp_event_end
//   csr      in         csr_wr_en              csr_index, csr_wr_data
//
// One beat per cycle while rsp_stall does not hold the result register; a taken
// beat sits in the input register until the parser step, which writes any result
// into the result register that drives rsp_valid.
// At most one result per beat; the parser steps only when the result
// register is empty or being drained, so rsp_stall backs up into req_stall.
// Synchronous reset clears the scan state and all config registers.
`default_nettype none

module event_record_window_scanner_core #(
   parameter int DAY_MINUTES = 1440
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_first_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_found,
   output logic signed [31:0] rsp_event_start,
   output logic signed [31:0] rsp_event_end,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_wr_data
);

   erws_pkg::cfg_type  cfg_ff, cfg_in;
   erws_pkg::emit_type emit;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_first_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_found_ff;
   logic [31:0] rsp_start_ff, rsp_end_ff;
   logic       out_free, step_en, req_take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step_en   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            erws_pkg::REG_RECORD_FLAGS: cfg_in.record_flags = csr_wr_data[7:0];
            erws_pkg::REG_RECORD_COUNT: cfg_in.record_count = csr_wr_data[15:0];
            erws_pkg::REG_DAY_START:    cfg_in.day_start    = csr_wr_data;
            erws_pkg::REG_DAY_END:      cfg_in.day_end      = csr_wr_data;
            default:                    cfg_in              = cfg_ff;
         endcase
      end
   end

   always_comb begin
      if (req_take)
         in_valid_in = 1'b1;
      else if (step_en)
         in_valid_in = 1'b0;
      else
         in_valid_in = in_valid_ff;

      if (step_en && emit.valid)
         rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall)
         rsp_valid_in = 1'b0;
      else
         rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_data_byte;
         in_first_ff <= req_first_byte;
      end
      if (step_en && emit.valid) begin
         rsp_found_ff <= emit.found;
         rsp_start_ff <= emit.event_start;
         rsp_end_ff   <= emit.event_end;
      end
   end

   erws_parser #(
      .DAY_MINUTES(DAY_MINUTES)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step_en),
      .data_byte  (in_byte_ff),
      .first_byte (in_first_ff),
      .cfg        (cfg_ff),
      .emit       (emit)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_event_start = $signed(rsp_start_ff);
   assign rsp_event_end   = $signed(rsp_end_ff);

   a_rsp_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step_en))
      else $error("result raised without a parser step");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_start_ff == 32'd0 && rsp_end_ff == 32'd0)
      else $error("not-found result carries nonzero dates");

   a_beat_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step_en |=> in_valid_ff && $stable(in_byte_ff)
                                  && $stable(in_first_ff))
      else $error("held input beat lost or overwritten");

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking bench for event_record_window_scanner_core: byte beats with random bursts
// and gaps, a clocked predictor of the record scan, and per-field result checks.
// Depends on erws_pkg and the scanner RTL only.
`timescale 1ns / 1ps

module testbench;

   localparam int DAY_MINUTES   = 1440;
   localparam int DAY_SECONDS   = 86400;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 12;
   localparam int LONG_HOLD     = 300;
   localparam int QUIET_LIMIT   = 3000;
   localparam int TARGET_BEATS  = 700;
   localparam int TARGET_HITS   = 40;
   localparam int MAX_PHASES    = 400;

   typedef struct packed {
      logic [7:0] data;
      logic       restart;
   } byte_beat_type;

   typedef struct packed {
      logic        found;
      logic [31:0] start_s;
      logic [31:0] end_s;
   } hit_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_type;
   typedef enum {KIND_CLEAN, KIND_NOISE, KIND_CUT} phase_kind_type;

   logic clock;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_first_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_found;
   logic signed [31:0] rsp_event_start;
   logic signed [31:0] rsp_event_end;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = erws_pkg::REG_RECORD_FLAGS;
   logic [31:0] csr_wr_data = 32'h0;

   event_record_window_scanner_core #(
      .DAY_MINUTES(DAY_MINUTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_first_byte(req_first_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_found(rsp_found),
      .rsp_event_start(rsp_event_start),
      .rsp_event_end(rsp_event_end),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // register copies
   logic [7:0]         flags_q = 8'h00;
   logic [15:0]        count_q = 16'h0000;
   logic signed [31:0] window_lo = 32'sh0;
   logic signed [31:0] window_hi = 32'sh0;

   // scan state
   erws_pkg::phase_type scan_phase = erws_pkg::PH_DATE;
   logic [1:0]  field_pos = 2'd0;
   logic [31:0] shift_reg = 32'h0;
   logic [31:0] running_date = 32'h0;
   logic [31:0] second_date = 32'h0;
   logic [31:0] last_start = 32'h0;
   logic [31:0] last_end = 32'h0;
   logic [15:0] record_no = 16'h0;
   logic        scan_done = 1'b0;

   byte_beat_type byte_stream[$];
   hit_type       pending_hits[$];

   int error_count = 0;
   int queued_beats = 0;
   int parsed_beats = 0;
   int results_seen = 0;
   int found_seen = 0;
   int settings_used = 0;
   int quiet_cycles = 0;

   task automatic report(input string msg);
      error_count++;
      $display("mismatch at %0t: %s", $time, msg);
   endtask

   function automatic bit phase_on(input erws_pkg::phase_type p);
      case (p)
         erws_pkg::PH_DATE:    return 1'b1;
         erws_pkg::PH_DATE2:   return flags_q[erws_pkg::FLAG_DATE2];
         erws_pkg::PH_PLANET1: return flags_q[erws_pkg::FLAG_PLANET1];
         erws_pkg::PH_PLANET2: return flags_q[erws_pkg::FLAG_PLANET2];
         erws_pkg::PH_DEGREE:  return flags_q[erws_pkg::FLAG_DEGREE];
         default:              return 1'b0;
      endcase
   endfunction

   function automatic erws_pkg::phase_type skip_to(input erws_pkg::phase_type p);
      erws_pkg::phase_type q;
      q = p;
      while (q < erws_pkg::PH_DONE && !phase_on(q))
         q = erws_pkg::phase_type'(q + 1);
      return q;
   endfunction

   function automatic int field_bytes(input erws_pkg::phase_type p);
      case (p)
         erws_pkg::PH_DATE: begin
            if (record_no != 0 && flags_q[erws_pkg::FLAG_BYTE_DELTA])
               return 1;
            else if (record_no != 0 && flags_q[erws_pkg::FLAG_WORD_DELTA])
               return 2;
            else
               return 4;
         end
         erws_pkg::PH_DATE2:  return 4;
         erws_pkg::PH_DEGREE: return flags_q[erws_pkg::FLAG_SHORT_DEGREE] ? 1 : 2;
         default:             return 1;
      endcase
   endfunction

   function automatic bit last_in_window();
      if (last_start == 32'h0)
         return 1'b0;
      return $signed(last_start) >= window_lo && $signed(last_start) < window_hi;
   endfunction

   task automatic close_scan();
      hit_type h;
      h.found   = last_in_window();
      h.start_s = h.found ? last_start : 32'h0;
      h.end_s   = h.found ? last_end : 32'h0;
      pending_hits.push_back(h);
      scan_done = 1'b1;
   endtask

   task automatic clear_scan();
      scan_phase   = erws_pkg::PH_DATE;
      field_pos    = 2'd0;
      shift_reg    = 32'h0;
      running_date = 32'h0;
      second_date  = 32'h0;
      last_start   = 32'h0;
      last_end     = 32'h0;
      record_no    = 16'h0;
      scan_done    = 1'b0;
   endtask

   task automatic scan_beat(input logic [7:0] b, input logic restart);
      logic [31:0] delta;
      logic [31:0] start_now;
      logic [31:0] end_now;
      if (restart)
         clear_scan();
      if (scan_done)
         return;
      parsed_beats++;
      if (record_no >= count_q) begin
         close_scan();
         return;
      end
      if (scan_phase >= erws_pkg::PH_DONE)
         scan_phase = skip_to(erws_pkg::PH_DATE);
      shift_reg = {shift_reg[23:0], b};
      field_pos = field_pos + 2'd1;
      if (field_pos != 2'd0 && field_pos < field_bytes(scan_phase))
         return;
      if (scan_phase == erws_pkg::PH_DATE) begin
         if (record_no != 0 && flags_q[erws_pkg::FLAG_BYTE_DELTA]) begin
            delta = {{24{shift_reg[7]}}, shift_reg[7:0]};
            running_date = running_date + (delta + DAY_MINUTES) * 32'd60;
         end else if (record_no != 0 && flags_q[erws_pkg::FLAG_WORD_DELTA]) begin
            delta = {{16{shift_reg[15]}}, shift_reg[15:0]};
            running_date = running_date + (delta + DAY_MINUTES) * 32'd60;
         end else begin
            running_date = shift_reg;
         end
      end else if (scan_phase == erws_pkg::PH_DATE2) begin
         second_date = shift_reg;
      end
      shift_reg  = 32'h0;
      field_pos  = 2'd0;
      scan_phase = skip_to(erws_pkg::phase_type'(scan_phase + 1));
      if (scan_phase < erws_pkg::PH_DONE)
         return;
      scan_phase = erws_pkg::PH_DATE;
      start_now  = running_date;
      end_now    = flags_q[erws_pkg::FLAG_DATE2] ? second_date : running_date;
      if (flags_q[erws_pkg::FLAG_CHAINED_END])
         last_end = start_now;
      if (last_in_window()) begin
         close_scan();
         return;
      end
      last_start = start_now;
      last_end   = end_now;
      record_no  = record_no + 16'd1;
      if (record_no >= count_q || record_no == 16'd0)
         close_scan();
   endtask

   // sender: bursts of random length separated by random gaps
   int burst_left = 0;
   int idle_left = 0;

   always @(posedge clock) begin : sender
      byte_beat_type beat;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (idle_left != 0 || byte_stream.size() == 0) begin
            req_valid <= 1'b0;
            if (idle_left != 0)
               idle_left--;
         end else begin
            beat = byte_stream.pop_front();
            req_valid      <= 1'b1;
            req_data_byte  <= beat.data;
            req_first_byte <= beat.restart;
            if (burst_left == 0) begin
               burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 16);
               idle_left  = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end
      end
   end

   always @(posedge clock) begin : take_beat
      if (!reset && req_valid && !req_stall)
         scan_beat(req_data_byte, req_first_byte);
   end

   // receiver: stall pattern of its own, plus long hold-offs once results flow
   stall_mode_type stall_mode = STALL_NONE;
   int mode_left = 0;
   int hold_left = 0;
   int long_holds = 0;

   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (rsp_valid && long_holds < 2 && results_seen >= 20 + 30 * long_holds) begin
         hold_left = LONG_HOLD - 1;
         long_holds++;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(8, 80);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= !rsp_stall;
         endcase
      end
   end

   always @(posedge clock) begin : check_results
      hit_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_hits.size() == 0) begin
            report($sformatf("unexpected result found=%0b start=%0d end=%0d",
                             rsp_found, rsp_event_start, rsp_event_end));
         end else begin
            want = pending_hits.pop_front();
            if (want.found)
               found_seen++;
            if (rsp_found !== want.found)
               report($sformatf("found %0b, want %0b", rsp_found, want.found));
            if (rsp_event_start !== want.start_s)
               report($sformatf("event_start %0d, want %0d",
                                rsp_event_start, $signed(want.start_s)));
            if (rsp_event_end !== want.end_s)
               report($sformatf("event_end %0d, want %0d",
                                rsp_event_end, $signed(want.end_s)));
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_beat(input logic [7:0] b, input logic restart);
      byte_beat_type beat;
      beat.data    = b;
      beat.restart = restart;
      byte_stream.push_back(beat);
      queued_beats++;
   endtask

   task automatic push_word(input logic [31:0] w);
      push_beat(w[31:24], 1'b0);
      push_beat(w[23:16], 1'b0);
      push_beat(w[15:8], 1'b0);
      push_beat(w[7:0], 1'b0);
   endtask

   // sample at the falling edge so the sender's last pop and valid have settled
   task automatic settle();
      @(negedge clock);
      while (byte_stream.size() != 0 || req_valid || pending_hits.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input erws_pkg::csr_index_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      case (idx)
         erws_pkg::REG_RECORD_FLAGS: flags_q   = value[7:0];
         erws_pkg::REG_RECORD_COUNT: count_q   = value[15:0];
         erws_pkg::REG_DAY_START:    window_lo = value;
         default:                    window_hi = value;
      endcase
   endtask

   task automatic end_writes();
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic apply_settings(input logic [7:0] flags, input logic [15:0] count,
                                 input logic [31:0] lo, input logic [31:0] hi);
      write_reg(erws_pkg::REG_RECORD_FLAGS, {24'h0, flags});
      write_reg(erws_pkg::REG_RECORD_COUNT, {16'h0, count});
      write_reg(erws_pkg::REG_DAY_START, lo);
      write_reg(erws_pkg::REG_DAY_END, hi);
      end_writes();
      settings_used++;
   endtask

   // well-formed records for the current flags, optionally cut short
   task automatic queue_scan(input int n_rec, input logic [31:0] base, input bit restart,
                             input bit cut);
      logic [7:0]  bytes[$];
      logic [31:0] date;
      int          keep;
      date = base;
      for (int r = 0; r < n_rec; r++) begin
         if (r == 0 || !(flags_q[erws_pkg::FLAG_BYTE_DELTA]
                         || flags_q[erws_pkg::FLAG_WORD_DELTA])) begin
            case ($urandom_range(0, 15))
               0:       date = 32'h0;
               1:       date = $urandom;
               default: date = base + r * DAY_SECONDS + $urandom_range(0, DAY_SECONDS - 1);
            endcase
            bytes.push_back(date[31:24]);
            bytes.push_back(date[23:16]);
            bytes.push_back(date[15:8]);
            bytes.push_back(date[7:0]);
         end else if (flags_q[erws_pkg::FLAG_BYTE_DELTA]) begin
            bytes.push_back(8'($urandom));
         end else begin
            bytes.push_back(8'($urandom));
            bytes.push_back(8'($urandom));
         end
         if (flags_q[erws_pkg::FLAG_DATE2]) begin
            date = $urandom_range(0, 7) == 0 ? $urandom : date + $urandom_range(0, 7200);
            bytes.push_back(date[31:24]);
            bytes.push_back(date[23:16]);
            bytes.push_back(date[15:8]);
            bytes.push_back(date[7:0]);
         end
         if (flags_q[erws_pkg::FLAG_PLANET1])
            bytes.push_back(8'($urandom));
         if (flags_q[erws_pkg::FLAG_PLANET2])
            bytes.push_back(8'($urandom));
         if (flags_q[erws_pkg::FLAG_DEGREE]) begin
            bytes.push_back(8'($urandom));
            if (!flags_q[erws_pkg::FLAG_SHORT_DEGREE])
               bytes.push_back(8'($urandom));
         end
      end
      keep = bytes.size();
      if (cut && keep > 1)
         keep = $urandom_range(1, keep - 1);
      for (int i = 0; i < keep; i++)
         push_beat(bytes[i], restart && i == 0);
   endtask

   initial begin : stimulus
      phase_kind_type kind;
      logic [7:0]  flags;
      logic [15:0] count;
      logic [31:0] base;
      logic [31:0] lo;
      logic [31:0] hi;
      int          scans;
      int          n_rec;
      int          phase_no;
      bit          was_cut;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // count zero at reset values, then a byte after the scan has finished
      push_beat(8'h00, 1'b1);
      push_beat(8'hFF, 1'b0);
      settle();

      // chained ends with byte deltas at both extremes, zero first start, full window
      apply_settings(8'h90, 16'd3, 32'h8000_0000, 32'h7FFF_FFFF);
      push_beat(8'h00, 1'b1);
      push_beat(8'h00, 1'b0);
      push_beat(8'h00, 1'b0);
      push_beat(8'h00, 1'b0);
      push_beat(8'h80, 1'b0);
      push_beat(8'h7F, 1'b0);
      settle();

      // every field, short degree, last record hit on the final count check
      apply_settings(8'h6F, 16'd1, -32'sd1000, 32'h0);
      push_beat(8'hFF, 1'b1);
      push_beat(8'hFF, 1'b0);
      push_beat(8'hFF, 1'b0);
      push_beat(8'hFF, 1'b0);
      push_word(32'h7FFF_FFFF);
      push_beat(8'hAA, 1'b0);
      push_beat(8'h55, 1'b0);
      push_beat(8'h00, 1'b0);
      settle();

      // empty window, count lowered in the middle of a word delta
      apply_settings(8'h20, 16'd5, 32'h7FFF_FFFF, 32'h8000_0000);
      push_beat(8'h00, 1'b1);
      push_beat(8'h00, 1'b0);
      push_beat(8'h00, 1'b0);
      push_beat(8'h10, 1'b0);
      push_beat(8'h7F, 1'b0);
      settle();
      write_reg(erws_pkg::REG_RECORD_COUNT, 32'd1);
      end_writes();
      push_beat(8'h33, 1'b0);
      settle();

      was_cut = 1'b0;
      phase_no = 0;
      while ((queued_beats < TARGET_BEATS || results_seen < TARGET_HITS)
             && phase_no < MAX_PHASES) begin
         case ($urandom_range(0, 9))
            0, 1:    kind = KIND_NOISE;
            2, 3:    kind = KIND_CUT;
            default: kind = KIND_CLEAN;
         endcase
         flags = 8'($urandom);
         case ($urandom_range(0, 11))
            0:       count = 16'h0000;
            1:       count = 16'hFFFF;
            default: count = 16'($urandom_range(1, 8));
         endcase
         if (phase_no == 0) begin
            flags = 8'hFF;
            count = 16'hFFFF;
         end else if (phase_no == 1) begin
            flags = 8'h00;
         end
         base = $urandom;
         case ($urandom_range(0, 9))
            0: begin
               lo = 32'h8000_0000;
               hi = 32'h7FFF_FFFF;
            end
            1: begin
               lo = $urandom;
               hi = $urandom;
            end
            default: begin
               lo = base + $urandom_range(0, 8) * DAY_SECONDS;
               hi = lo + $urandom_range(0, 4) * DAY_SECONDS;
            end
         endcase
         apply_settings(flags, count, lo, hi);

         if (kind == KIND_NOISE) begin
            n_rec = $urandom_range(10, 40);
            for (int i = 0; i < n_rec; i++)
               push_beat(8'($urandom), $urandom_range(0, 11) == 0);
         end else begin
            scans = (count == 0 || count > 16) ? 1 : $urandom_range(1, 3);
            for (int s = 0; s < scans; s++) begin
               if (count == 0 || count > 16)
                  n_rec = $urandom_range(2, 10);
               else
                  n_rec = count + ($urandom_range(0, 5) == 0 ? 1 : 0);
               queue_scan(n_rec, base, !(s == 0 && was_cut && $urandom_range(0, 1)),
                          kind == KIND_CUT && s == scans - 1);
            end
         end
         was_cut = (kind != KIND_CLEAN);
         settle();
         phase_no++;
      end

      @(negedge clock);
      while (byte_stream.size() != 0 || req_valid || pending_hits.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_hits.size() != 0)
         report($sformatf("%0d results never arrived", pending_hits.size()));

      $display("Sent %0d beats (%0d parsed) under %0d register settings, cut and restarted.",
               queued_beats, parsed_beats, settings_used);
      $display("Checked %0d results (%0d in-window records), %0d long receiver hold-offs.",
               results_seen, found_seen, long_holds);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
